/* sv/wpp_pkg.sv */
// Shared types, codes and constants of the WAV PCM16 mono downmix parser.
package wpp_pkg;

    localparam int FMT_MAX_BYTES_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] FMT_PCM = 16'd1;
    localparam logic [15:0] PCM_BITS = 16'd16;
    localparam logic [15:0] CHAN_MONO = 16'd1;
    localparam logic [15:0] CHAN_STEREO = 16'd2;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NOT_WAVE = 3'd0;
    localparam logic [2:0] ERR_FMT_LARGE = 3'd1;
    localparam logic [2:0] ERR_NOT_PCM = 3'd2;
    localparam logic [2:0] ERR_NOT_16BIT = 3'd3;
    localparam logic [2:0] ERR_BAD_CHAN = 3'd4;
    localparam logic [2:0] ERR_DATA_FIRST = 3'd5;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       file_start;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample;
        logic               end_of_data;
        logic [1:0]         channels;
        logic [31:0]        sample_rate;
        logic [2:0]         error_code;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic        stereo;
        logic        eod;
        logic [1:0]  channels;
        logic [31:0] rate;
        logic [2:0]  err;
    } t_event;

endpackage

/* sv/wpp_front.sv */
// Byte parser: walks the RIFF/WAVE stream and classifies each byte into events.
module wpp_front
    import wpp_pkg::*;
#(
    parameter int FMT_MAX_BYTES = FMT_MAX_BYTES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_ev_valid,
    output t_event   o_ev
);

    localparam int CNT_W = $clog2(FMT_MAX_BYTES + 1);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_CHUNK = 3'd1;
    localparam logic [2:0] PH_FMT = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_IDLE = 3'd5;

    logic [2:0]       r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_tag, n_tag;
    logic [31:0]      r_len, n_len;
    logic [15:0]      r_fmt, n_fmt;
    logic [15:0]      r_chan, n_chan;
    logic [31:0]      r_rate, n_rate;
    logic [15:0]      r_bits, n_bits;
    logic             r_fmt_seen, n_fmt_seen;
    logic [31:0]      r_data_left, n_data_left;
    logic [7:0]       r_low, n_low;
    logic [15:0]      r_left, n_left;
    logic [1:0]       r_fidx, n_fidx;
    logic             r_hdr_bad, n_hdr_bad;
    logic [32:0]      r_skip, n_skip;

    logic             ev_valid;
    t_event           ev;
    logic [7:0]       b;
    logic [CNT_W-1:0] i;
    logic [15:0]      word;
    logic             stereo;

    assign b = i_item.byte_value;

    always_comb begin
        n_phase = r_phase;
        n_cnt = r_cnt;
        n_tag = r_tag;
        n_len = r_len;
        n_fmt = r_fmt;
        n_chan = r_chan;
        n_rate = r_rate;
        n_bits = r_bits;
        n_fmt_seen = r_fmt_seen;
        n_data_left = r_data_left;
        n_low = r_low;
        n_left = r_left;
        n_fidx = r_fidx;
        n_hdr_bad = r_hdr_bad;
        n_skip = r_skip;
        ev_valid = 1'b0;
        ev = '0;
        i = '0;
        word = '0;
        stereo = 1'b0;
        if (i_accept) begin
            if (i_item.file_start) begin
                n_phase = PH_HEADER;
                n_cnt = '0;
                n_fmt_seen = 1'b0;
                n_fidx = '0;
                n_hdr_bad = 1'b0;
                n_tag = '0;
                n_len = '0;
                n_fmt = '0;
                n_chan = '0;
                n_rate = '0;
                n_bits = '0;
            end
            i = n_cnt;
            unique case (n_phase)
                PH_HEADER: begin
                    if (i < CNT_W'(4) || i >= CNT_W'(8)) begin
                        n_tag = {n_tag[23:0], b};
                    end
                    if (i == CNT_W'(3) && n_tag != TAG_RIFF) begin
                        n_hdr_bad = 1'b1;
                    end
                    n_cnt = i + CNT_W'(1);
                    if (i == CNT_W'(11)) begin
                        if (n_tag != TAG_WAVE) begin
                            n_hdr_bad = 1'b1;
                        end
                        if (n_hdr_bad) begin
                            n_phase = PH_IDLE;
                            ev_valid = 1'b1;
                            ev.kind = KIND_ERROR;
                            ev.err = ERR_NOT_WAVE;
                        end else begin
                            n_cnt = '0;
                            n_phase = PH_CHUNK;
                        end
                    end
                end
                PH_CHUNK: begin
                    if (i == '0) begin
                        n_tag = '0;
                        n_len = '0;
                    end
                    if (i < CNT_W'(4)) begin
                        n_tag = {n_tag[23:0], b};
                    end else begin
                        n_len[{i[1:0], 3'b000} +: 8] = b;
                    end
                    n_cnt = i + CNT_W'(1);
                    if (i == CNT_W'(7)) begin
                        n_cnt = '0;
                        if (n_tag == TAG_FMT) begin
                            if (n_len > 32'(FMT_MAX_BYTES)) begin
                                n_phase = PH_IDLE;
                                ev_valid = 1'b1;
                                ev.kind = KIND_ERROR;
                                ev.err = ERR_FMT_LARGE;
                            end else begin
                                n_fmt = '0;
                                n_chan = '0;
                                n_rate = '0;
                                n_bits = '0;
                                n_fmt_seen = 1'b0;
                                n_phase = PH_FMT;
                                if (n_len == '0) begin
                                    n_phase = PH_IDLE;
                                    ev_valid = 1'b1;
                                    ev.kind = KIND_ERROR;
                                    ev.err = ERR_NOT_PCM;
                                end
                            end
                        end else if (n_tag == TAG_DATA) begin
                            if (!n_fmt_seen) begin
                                n_phase = PH_IDLE;
                                ev_valid = 1'b1;
                                ev.kind = KIND_ERROR;
                                ev.err = ERR_DATA_FIRST;
                            end else begin
                                n_data_left = n_len;
                                n_fidx = '0;
                                n_phase = (n_len == '0) ? PH_IDLE : PH_DATA;
                                ev_valid = 1'b1;
                                ev.kind = KIND_FORMAT;
                                ev.channels = n_chan[1:0];
                                ev.rate = n_rate;
                            end
                        end else begin
                            n_skip = {1'b0, n_len} + {32'd0, n_len[0]};
                            n_phase = (n_len == '0) ? PH_CHUNK : PH_SKIP;
                        end
                    end
                end
                PH_FMT: begin
                    if (i < CNT_W'(2)) begin
                        n_fmt[{i[0], 3'b000} +: 8] = n_fmt[{i[0], 3'b000} +: 8] | b;
                    end else if (i < CNT_W'(4)) begin
                        n_chan[{i[0], 3'b000} +: 8] = n_chan[{i[0], 3'b000} +: 8] | b;
                    end else if (i < CNT_W'(8)) begin
                        n_rate[{i[1:0], 3'b000} +: 8] = n_rate[{i[1:0], 3'b000} +: 8] | b;
                    end else if (i == CNT_W'(14) || i == CNT_W'(15)) begin
                        n_bits[{i[0], 3'b000} +: 8] = n_bits[{i[0], 3'b000} +: 8] | b;
                    end
                    n_cnt = i + CNT_W'(1);
                    if (32'(n_cnt) >= n_len) begin
                        if (n_fmt != FMT_PCM) begin
                            n_phase = PH_IDLE;
                            ev_valid = 1'b1;
                            ev.kind = KIND_ERROR;
                            ev.err = ERR_NOT_PCM;
                        end else if (n_bits != PCM_BITS) begin
                            n_phase = PH_IDLE;
                            ev_valid = 1'b1;
                            ev.kind = KIND_ERROR;
                            ev.err = ERR_NOT_16BIT;
                        end else if (n_chan != CHAN_MONO && n_chan != CHAN_STEREO) begin
                            n_phase = PH_IDLE;
                            ev_valid = 1'b1;
                            ev.kind = KIND_ERROR;
                            ev.err = ERR_BAD_CHAN;
                        end else begin
                            n_fmt_seen = 1'b1;
                            n_cnt = '0;
                            if (n_len[0]) begin
                                n_skip = 33'd1;
                                n_phase = PH_SKIP;
                            end else begin
                                n_phase = PH_CHUNK;
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    n_skip = n_skip - 33'd1;
                    if (n_skip == '0) begin
                        n_cnt = '0;
                        n_phase = PH_CHUNK;
                    end
                end
                PH_DATA: begin
                    stereo = (n_chan == CHAN_STEREO);
                    n_data_left = n_data_left - 32'd1;
                    if (n_data_left == '0) begin
                        n_phase = PH_IDLE;
                    end
                    if (!n_fidx[0]) begin
                        n_low = b;
                        n_fidx = n_fidx + 2'd1;
                    end else begin
                        word = {b, n_low};
                        if (stereo && n_fidx == 2'd1) begin
                            n_left = word;
                            n_fidx = 2'd2;
                        end else begin
                            n_fidx = '0;
                            ev_valid = 1'b1;
                            ev.kind = KIND_SAMPLE;
                            ev.word_a = n_left;
                            ev.word_b = word;
                            ev.stereo = stereo;
                            ev.eod = n_data_left < (stereo ? 32'd4 : 32'd2);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_cnt <= '0;
            r_fmt_seen <= 1'b0;
            r_fidx <= '0;
            r_hdr_bad <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt <= n_cnt;
            r_fmt_seen <= n_fmt_seen;
            r_fidx <= n_fidx;
            r_hdr_bad <= n_hdr_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
        r_len <= n_len;
        r_fmt <= n_fmt;
        r_chan <= n_chan;
        r_rate <= n_rate;
        r_bits <= n_bits;
        r_data_left <= n_data_left;
        r_low <= n_low;
        r_left <= n_left;
        r_skip <= n_skip;
    end

    assign o_ev_valid = ev_valid;
    assign o_ev = ev;

endmodule

/* sv/wpp_queue.sv */
// Short event queue between the parser and the sample back end.
module wpp_queue
    import wpp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_event o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_event           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;
    assign o_data = r_mem[r_rd];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* sv/wpp_back.sv */
// Back end: stereo downmix, result formatting and the output register.
module wpp_back
    import wpp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_ev_valid,
    input  t_event    i_ev,
    output logic      o_ev_pop,
    output logic      o_valid,
    input  logic      i_pop,
    output t_out_item o_result
);

    logic        r_valid, n_valid;
    t_out_item   r_result;
    t_out_item   result;
    logic [16:0] sum;
    logic [16:0] sum_adj;
    logic        load;

    assign load = i_ev_valid && (!r_valid || i_pop);
    assign o_ev_pop = load;

    always_comb begin
        sum = {i_ev.word_a[15], i_ev.word_a} + {i_ev.word_b[15], i_ev.word_b};
        sum_adj = sum + {16'd0, sum[16]};
        result = '0;
        result.kind = i_ev.kind;
        result.error_code = i_ev.err;
        result.channels = i_ev.channels;
        result.sample_rate = i_ev.rate;
        if (i_ev.kind == KIND_SAMPLE) begin
            result.sample = i_ev.stereo ? sum_adj[16:1] : i_ev.word_b;
            result.end_of_data = i_ev.eod;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= result;
        end
    end

    assign o_valid = r_valid;
    assign o_result = r_result;

endmodule

/* sv/wav_pcm16_parser_mono_downmix.sv */
// Top level of the WAV PCM16 parser with stereo to mono downmix.
//
// Channel   Direction  Handshake           Payload
// input     in         push / full         i_item   (byte_value, file_start)
// result    out        empty / pop         o_result (kind, sample, end_of_data,
//                                                    channels, sample_rate, error_code)
//
// One byte is accepted every cycle while the event queue has room; the parser updates its
// state in the cycle of acceptance. An accepted byte's event is written into the event
// queue, then into the output register when that is free. Results leave at one per cycle
// while pop is held and events wait; the queue and output register hold QUEUE_DEPTH + 1
// results (three by default), and full rises only when the queue is full, so the input
// stalls only under result stalls. Reset is synchronous; no clearing pass follows it.
module wav_pcm16_parser_mono_downmix
    import wpp_pkg::*;
#(
    parameter int FMT_MAX_BYTES = FMT_MAX_BYTES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_item  i_item,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    logic   accept;
    logic   ev_valid;
    t_event ev_in;
    t_event ev_head;
    logic   q_empty;
    logic   ev_pop;
    logic   out_valid;

    assign accept = push && !full;

    wpp_front #(
        .FMT_MAX_BYTES(FMT_MAX_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_item),
        .o_ev_valid(ev_valid),
        .o_ev      (ev_in)
    );

    wpp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (ev_valid),
        .i_data (ev_in),
        .o_full (full),
        .i_pop  (ev_pop),
        .o_empty(q_empty),
        .o_data (ev_head)
    );

    wpp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ev_valid(!q_empty),
        .i_ev      (ev_head),
        .o_ev_pop  (ev_pop),
        .o_valid   (out_valid),
        .i_pop     (pop),
        .o_result  (o_result)
    );

    assign empty = !out_valid;

`ifndef SYNTHESIS
    a_full_implies_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("event queue full while output register is empty");

    a_error_code_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == KIND_ERROR) |->
            (o_result.error_code != 3'd6 && o_result.error_code != 3'd7))
        else $error("error item carries an undefined code");

    a_format_channels : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == KIND_FORMAT) |->
            (o_result.channels == 2'd1 || o_result.channels == 2'd2))
        else $error("format item carries a bad channel count");

    a_sample_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == KIND_SAMPLE) |->
            (o_result.channels == 2'd0 && o_result.error_code == 3'd0))
        else $error("sample item carries format or error fields");
`endif

endmodule
